>>> rtl/core/conv5_pkg.sv
// Package with the state type, register indexes and constants of the 5x5 convolution filter.
`default_nettype none

package conv5_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_FRAME_WIDTH  = 3'd0;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 3'd1;
  localparam cfg_idx_t REG_DIVISOR      = 3'd2;
  localparam cfg_idx_t REG_COEFS_LOW    = 3'd3;
  localparam cfg_idx_t REG_COEFS_MID    = 3'd4;
  localparam cfg_idx_t REG_COEFS_HIGH   = 3'd5;
  localparam cfg_idx_t REG_COEF_LAST    = 3'd6;

  localparam int KernelSize = 5;
  localparam int NumTaps    = KernelSize * KernelSize;
  localparam int ColSumW    = 19;
  localparam int AccW       = 21;
  localparam int RemW       = 24;
  localparam int QuoW       = 9;
  localparam logic [7:0] PixMax = 8'd255;

endpackage

`default_nettype wire

>>> rtl/core/conv5x5_zero_pad_filter.sv
// Top level of the streaming 5x5 zero-padded convolution filter.
//
// Pixels enter in raster order on the s_axis channel: tdata carries the luma
// and three pass-through channels, tuser marks a flush beat that drains the
// tail after the last pixel of a frame. Results leave on m_axis, tlast
// marking the last pixel of the frame. A result lags its pixel by 2*width+2
// input beats. The register port sets frame size, divisor and coefficients;
// the frame size is taken at the first beat of each frame.
// A beat that produces no result occupies the block for the line-buffer read
// and its write-back. A beat that produces a result goes through the read,
// the write-back, five column steps of the multiply-accumulate over the
// window, nine steps of the restoring divider and the load of the output
// register.
// A finished result waits in the output register while the next beat is
// already accepted; if the receiver stalls, the block halts before loading
// the following result. Reset clears all counters and the output valid; the
// line buffers keep their contents, which are never seen before being written.
`default_nettype none

module conv5x5_zero_pad_filter
  import conv5_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: luma_in, chan_one_in, chan_two_in, alpha_in
  input  wire logic [31:0] s_axis_tdata,
  // tuser: action
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: filtered, chan_one_out, chan_two_out, alpha_out
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_we_i,
  input  wire cfg_idx_t    cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = CW + 1;
  localparam int RW  = 13;
  localparam int VW  = WW + RW;
  localparam int LW  = WW + 2;
  localparam int PD  = 2 * MAX_WIDTH + 3;
  localparam int PAW = $clog2(PD);

  state_e state_q, state_d;

  logic [11:0] fw_q, fh_q;
  logic [15:0] div_q;
  logic [63:0] coefs_low_q, coefs_mid_q, coefs_high_q;
  logic [7:0]  coef_last_q;

  logic [WW-1:0]  act_w_q;
  logic [11:0]    act_h_q;
  logic [CW-1:0]  in_col_q, out_col_q;
  logic [RW-1:0]  in_row_q;
  logic [11:0]    out_row_q;
  logic [VW-1:0]  v_q;
  logic [PAW-1:0] wp_q, rp_q;

  logic [7:0]  luma_q;
  logic        prod_q;
  logic [CW-1:0] lb_addr_q;
  logic [7:0]  win_q [KernelSize][KernelSize];
  logic [3:0]  cnt_q;
  logic [AccW-1:0] acc_q, acc_d;
  logic [RemW-1:0] rem_q;
  logic [QuoW-1:0] quo_q;
  logic [31:0] m_tdata_q;
  logic        m_tlast_q, m_tvalid_q;

  logic [31:0] lbuf [MAX_WIDTH];
  logic [31:0] lbuf_rd_q;
  logic [23:0] pbuf [PD];
  logic [23:0] pbuf_rd_q;

  logic          accept, flush, start, filling, take, prod;
  logic [WW-1:0] cur_w, fw_clamp;
  logic [11:0]   cur_h;
  logic [LW-1:0] lag;
  logic          col_wrap;
  logic          out_free, load_out, last;

  logic [7:0]  coef_arr [NumTaps];
  logic [199:0] coefs_all;
  logic        row_ok [KernelSize];
  logic        col_ok [KernelSize];
  logic [13:0] rr [KernelSize];
  logic [WW+1:0] cc [KernelSize];
  logic [ColSumW-1:0] colsum;
  logic [7:0]  px [KernelSize];
  logic [15:0] dv;
  logic [RemW-1:0] dv_sh;
  logic        ge;
  logic [7:0]  col_in [KernelSize];
  logic [7:0]  q8;

  // Input side decisions.
  always_comb begin
    accept = s_axis_tvalid && s_axis_tready;
    flush  = s_axis_tuser;
    start  = (in_col_q == '0) && (in_row_q == '0);
    if (fw_q == 12'd0) begin
      fw_clamp = WW'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      fw_clamp = WW'(MAX_WIDTH);
    end else begin
      fw_clamp = WW'(fw_q);
    end
    cur_w    = start ? fw_clamp : act_w_q;
    cur_h    = start ? ((fh_q == 12'd0) ? 12'd1 : fh_q) : act_h_q;
    filling  = in_row_q < RW'(cur_h);
    take     = accept && !(flush && filling);
    lag      = LW'({cur_w, 1'b0}) + LW'(2);
    prod     = v_q >= VW'(lag);
    col_wrap = (WW'(in_col_q) + WW'(1)) >= cur_w;
  end

  // Window masks for zero padding.
  always_comb begin
    coefs_all = {coef_last_q, coefs_high_q, coefs_mid_q, coefs_low_q};
    for (int k = 0; k < NumTaps; k++) begin
      coef_arr[k] = coefs_all[8*k +: 8];
    end
    for (int i = 0; i < KernelSize; i++) begin
      rr[i]     = 14'(out_row_q) + 14'(i);
      row_ok[i] = (rr[i] >= 14'd2) && ((rr[i] - 14'd2) < 14'(act_h_q));
      cc[i]     = (WW+2)'(out_col_q) + (WW+2)'(i);
      col_ok[i] = (cc[i] >= (WW+2)'(2)) && ((cc[i] - (WW+2)'(2)) < (WW+2)'(act_w_q));
    end
  end

  // One window column of the multiply-accumulate per cycle.
  always_comb begin
    colsum = '0;
    for (int i = 0; i < KernelSize; i++) begin
      px[i]  = (row_ok[i] && col_ok[cnt_q[2:0]]) ? win_q[i][cnt_q[2:0]] : 8'd0;
      colsum = colsum + ColSumW'(px[i] * coef_arr[5'(i * KernelSize) + 5'(cnt_q)]);
    end
    acc_d = acc_q + AccW'(colsum);
  end

  always_comb begin
    dv    = (div_q == 16'd0) ? 16'd1 : div_q;
    dv_sh = RemW'(dv) << cnt_q;
    ge    = rem_q >= dv_sh;
    q8    = quo_q[8] ? PixMax : quo_q[7:0];
  end

  always_comb begin
    col_in[0] = lbuf_rd_q[31:24];
    col_in[1] = lbuf_rd_q[23:16];
    col_in[2] = lbuf_rd_q[15:8];
    col_in[3] = lbuf_rd_q[7:0];
    col_in[4] = luma_q;
  end

  always_comb begin
    last = ((13'(out_row_q) + 13'd1) >= 13'(act_h_q)) &&
           ((WW'(out_col_q) + WW'(1)) >= act_w_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (take) state_d = ST_RMW;
      ST_RMW:  state_d = prod_q ? ST_MAC : ST_IDLE;
      ST_MAC:  if (cnt_q == 4'd4) state_d = ST_DIV;
      ST_DIV:  if (cnt_q == 4'd0) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    out_free      = !m_tvalid_q || m_axis_tready;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_OUT:  load_out = out_free;
      default: ;
    endcase
  end

  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tlast  = m_tlast_q;
  assign m_axis_tvalid = m_tvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q         <= 12'd640;
      fh_q         <= 12'd480;
      div_q        <= 16'd1;
      coefs_low_q  <= '0;
      coefs_mid_q  <= '0;
      coefs_high_q <= '0;
      coef_last_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  fw_q         <= cfg_wdata_i[11:0];
        REG_FRAME_HEIGHT: fh_q         <= cfg_wdata_i[11:0];
        REG_DIVISOR:      div_q        <= cfg_wdata_i[15:0];
        REG_COEFS_LOW:    coefs_low_q  <= cfg_wdata_i;
        REG_COEFS_MID:    coefs_mid_q  <= cfg_wdata_i;
        REG_COEFS_HIGH:   coefs_high_q <= cfg_wdata_i;
        REG_COEF_LAST:    coef_last_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      act_w_q    <= WW'(640);
      act_h_q    <= 12'd480;
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      v_q        <= '0;
      wp_q       <= '0;
      rp_q       <= '0;
      prod_q     <= 1'b0;
      cnt_q      <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && start) begin
        act_w_q <= cur_w;
        act_h_q <= cur_h;
      end
      if (take) begin
        prod_q <= prod;
        v_q    <= v_q + VW'(1);
        if (col_wrap) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + RW'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
        if (filling) begin
          wp_q <= (wp_q == PAW'(PD - 1)) ? '0 : wp_q + PAW'(1);
        end
        if (prod) begin
          rp_q <= (rp_q == PAW'(PD - 1)) ? '0 : rp_q + PAW'(1);
        end
      end
      case (state_q)
        ST_RMW:  cnt_q <= '0;
        ST_MAC:  cnt_q <= (cnt_q == 4'd4) ? 4'd8 : cnt_q + 4'd1;
        ST_DIV:  cnt_q <= cnt_q - 4'd1;
        default: ;
      endcase
      if (load_out) begin
        m_tvalid_q <= 1'b1;
        if (last) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          v_q       <= '0;
          wp_q      <= '0;
          rp_q      <= '0;
        end else if ((WW'(out_col_q) + WW'(1)) >= act_w_q) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + 12'd1;
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      luma_q    <= filling ? s_axis_tdata[7:0] : 8'd0;
      lb_addr_q <= in_col_q;
    end
    if (state_q == ST_RMW) begin
      for (int i = 0; i < KernelSize; i++) begin
        for (int j = 0; j < KernelSize - 1; j++) begin
          win_q[i][j] <= win_q[i][j+1];
        end
        win_q[i][KernelSize-1] <= col_in[i];
      end
      acc_q <= '0;
    end
    if (state_q == ST_MAC) begin
      acc_q <= acc_d;
      if (cnt_q == 4'd4) begin
        rem_q <= RemW'(acc_d);
        quo_q <= '0;
      end
    end
    if (state_q == ST_DIV) begin
      if (ge) begin
        rem_q <= rem_q - dv_sh;
      end
      quo_q[cnt_q] <= ge;
    end
    if (load_out) begin
      m_tdata_q <= {pbuf_rd_q, q8};
      m_tlast_q <= last;
    end
  end

  // Line buffer: each entry holds the four rows above, newest in the low byte.
  always_ff @(posedge clk_i) begin
    if (take) begin
      lbuf_rd_q <= lbuf[in_col_q];
    end
    if (state_q == ST_RMW) begin
      lbuf[lb_addr_q] <= {lbuf_rd_q[23:0], luma_q};
    end
  end

  // Delay memory for the three pass-through channels.
  always_ff @(posedge clk_i) begin
    if (take && filling) begin
      pbuf[wp_q] <= s_axis_tdata[31:8];
    end
    if (take && prod) begin
      pbuf_rd_q <= pbuf[rp_q];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/conv5_checker.sv
// Port checker for the 5x5 convolution filter and its bind statement.
`default_nettype none

module conv5_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic [31:0] s_axis_tdata,
  input wire logic        s_axis_tuser,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready
);

  // No result is offered while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output beat offered during reset");

  // A stalled result keeps its data and frame marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

  // A pixel beat always occupies the line buffer for its write-back cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("input accepted during line buffer write-back");

endmodule

bind conv5x5_zero_pad_filter conv5_checker u_conv5_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the streaming 5x5 zero-padded convolution filter.
`timescale 1ns / 1ps

module tb_top;
  import conv5_pkg::*;

  localparam int WidthCap  = 2048;
  localparam int LumaDepth = 4 * WidthCap + 8;
  localparam int ChanDepth = 2 * WidthCap + 3;
  localparam int SettleCycles = 40;

  typedef struct {
    logic [7:0] filtered;
    logic [7:0] chan_one;
    logic [7:0] chan_two;
    logic [7:0] alpha;
    logic       frame_end;
  } pix_out_t;

  typedef struct {
    bit          is_cfg;
    cfg_idx_t    idx;
    logic [63:0] val;
    bit          flush;
    logic [7:0]  luma, c1, c2, a;
    bit          typed;
    pix_out_t    res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we_i = 1'b0;
  cfg_idx_t    cfg_idx_i = REG_FRAME_WIDTH;
  logic [63:0] cfg_wdata_i = '0;

  conv5x5_zero_pad_filter i_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tlast, .m_axis_tvalid, .m_axis_tready,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the filter state.
  logic [11:0]  sh_width = 12'd640, sh_height = 12'd480;
  logic [15:0]  sh_divisor = 16'd1;
  logic [63:0]  sh_coefs_low = '0, sh_coefs_mid = '0, sh_coefs_high = '0;
  logic [7:0]   sh_coef_last = '0;
  logic [7:0]   luma_hist [LumaDepth];
  logic [23:0]  chan_hist [ChanDepth];
  int unsigned  in_col = 0, in_row = 0, out_col = 0, out_row = 0;
  int unsigned  lat_w = 640, lat_h = 480;
  bit           frame_done = 1'b0;

  pix_out_t     pending_pix[$];
  int           n_errors = 0;
  int           n_results = 0;
  int           n_beats = 0;
  int           n_small = 0;
  bit           quiet = 1'b0;
  bit           pressure_done = 1'b0;
  int           hold_left = 0;

  function automatic bit filter_step(input bit flush, input logic [7:0] luma,
                                     input logic [7:0] c1, c2, a,
                                     output pix_out_t res);
    int unsigned v, lag, o, sum, q, rr, cc;
    logic [199:0] coef_vec;
    bit filling;
    res = '{default: '0};
    if (in_col == 0 && in_row == 0) begin
      lat_w = (sh_width == 0) ? 1 : ((sh_width > WidthCap) ? WidthCap : sh_width);
      lat_h = (sh_height == 0) ? 1 : sh_height;
    end
    filling = in_row < lat_h;
    if (flush && filling) return 1'b0;
    v = in_row * lat_w + in_col;
    if (filling) begin
      luma_hist[v % LumaDepth] = luma;
      chan_hist[v % ChanDepth] = {a, c2, c1};
    end
    in_col++;
    if (in_col >= lat_w) begin
      in_col = 0;
      in_row++;
    end
    lag = 2 * lat_w + 2;
    if (v < lag) return 1'b0;
    coef_vec = {sh_coef_last, sh_coefs_high, sh_coefs_mid, sh_coefs_low};
    sum = 0;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        rr = out_row + i;
        cc = out_col + j;
        if (rr >= 2 && rr - 2 < lat_h && cc >= 2 && cc - 2 < lat_w)
          sum += luma_hist[((rr - 2) * lat_w + (cc - 2)) % LumaDepth] *
                 coef_vec[8*(5*i+j) +: 8];
      end
    end
    q = sum / ((sh_divisor == 0) ? 1 : sh_divisor);
    if (q > 255) q = 255;
    o = out_row * lat_w + out_col;
    res.filtered = q[7:0];
    {res.alpha, res.chan_two, res.chan_one} = chan_hist[o % ChanDepth];
    res.frame_end = (out_row + 1 >= lat_h) && (out_col + 1 >= lat_w);
    if (res.frame_end) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_done = 1'b1;
    end else begin
      out_col++;
      if (out_col >= lat_w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_beat(input bit flush, input logic [7:0] luma, c1, c2, a,
                           input bit typed, input pix_out_t typed_res);
    pix_out_t res;
    while (!quiet && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= flush;
    s_axis_tdata  <= {a, c2, c1, luma};
    do @(posedge clk_i); while (!s_axis_tready);
    if (filter_step(flush, luma, c1, c2, a, res))
      pending_pix.push_back(typed ? typed_res : res);
    n_beats++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_pix.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_FRAME_WIDTH:  sh_width      = val[11:0];
      REG_FRAME_HEIGHT: sh_height     = val[11:0];
      REG_DIVISOR:      sh_divisor    = val[15:0];
      REG_COEFS_LOW:    sh_coefs_low  = val;
      REG_COEFS_MID:    sh_coefs_mid  = val;
      REG_COEFS_HIGH:   sh_coefs_high = val;
      REG_COEF_LAST:    sh_coef_last  = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_frame(input logic [11:0] w, h, input logic [15:0] div,
                           input logic [63:0] lo, mid, hi, input logic [7:0] last);
    write_reg(REG_FRAME_WIDTH, 64'(w));
    write_reg(REG_FRAME_HEIGHT, 64'(h));
    write_reg(REG_DIVISOR, 64'(div));
    write_reg(REG_COEFS_LOW, lo);
    write_reg(REG_COEFS_MID, mid);
    write_reg(REG_COEFS_HIGH, hi);
    write_reg(REG_COEF_LAST, 64'(last));
  endtask

  // Sends one frame with stray flush beats mixed in, then drains its tail.
  task automatic run_frame(input bit is_small);
    int unsigned w, h;
    pix_out_t none;
    none = '{default: '0};
    w = (sh_width == 0) ? 1 : ((sh_width > WidthCap) ? WidthCap : sh_width);
    h = (sh_height == 0) ? 1 : sh_height;
    frame_done = 1'b0;
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(9) == 0)
        send_beat(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  1'b0, none);
      send_beat(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                1'b0, none);
      if (is_small) n_small += 1;
    end
    while (!frame_done) begin
      send_beat($urandom_range(4) != 0, 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 1'b0, none);
      if (is_small) n_small += 1;
    end
  endtask

  function automatic stim_row_t cfg_row(input cfg_idx_t idx, input logic [63:0] val);
    cfg_row = '{default: '0};
    cfg_row.is_cfg = 1'b1;
    cfg_row.idx = idx;
    cfg_row.val = val;
  endfunction

  function automatic stim_row_t beat_row(input bit flush, input logic [7:0] l, c1, c2, a);
    beat_row = '{default: '0};
    beat_row.flush = flush;
    beat_row.luma = l; beat_row.c1 = c1; beat_row.c2 = c2; beat_row.a = a;
  endfunction

  function automatic stim_row_t chk_row(input bit flush, input logic [7:0] f, o1, o2, oa);
    chk_row = beat_row(flush, 8'h00, 8'h00, 8'h00, 8'h00);
    chk_row.typed = 1'b1;
    chk_row.res = '{f, o1, o2, oa, 1'b1};
  endfunction

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!pressure_done && n_small >= 100) begin
      pressure_done <= 1'b1;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_pix.size() == 0) begin
        $error("unexpected beat: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
        n_errors++;
      end else begin
        pix_out_t e;
        e = pending_pix.pop_front();
        n_results++;
        if (m_axis_tdata[7:0] !== e.filtered) begin
          $error("filtered: expected %h, actual %h", e.filtered, m_axis_tdata[7:0]);
          n_errors++;
        end
        if (m_axis_tdata[15:8] !== e.chan_one) begin
          $error("chan_one_out: expected %h, actual %h", e.chan_one, m_axis_tdata[15:8]);
          n_errors++;
        end
        if (m_axis_tdata[23:16] !== e.chan_two) begin
          $error("chan_two_out: expected %h, actual %h", e.chan_two, m_axis_tdata[23:16]);
          n_errors++;
        end
        if (m_axis_tdata[31:24] !== e.alpha) begin
          $error("alpha_out: expected %h, actual %h", e.alpha, m_axis_tdata[31:24]);
          n_errors++;
        end
        if (m_axis_tlast !== e.frame_end) begin
          $error("frame_end: expected %b, actual %b", e.frame_end, m_axis_tlast);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    logic [63:0] mask;
    int div_pick;
    rst_ni <= 1'b0;
    rows = '{
      cfg_row(REG_FRAME_WIDTH, 64'd1), cfg_row(REG_FRAME_HEIGHT, 64'd1),
      cfg_row(REG_DIVISOR, 64'd1), cfg_row(REG_COEFS_LOW, 64'd0),
      cfg_row(REG_COEFS_MID, 64'h0000_0001_0000_0000),
      cfg_row(REG_COEFS_HIGH, 64'd0), cfg_row(REG_COEF_LAST, 64'd0),
      beat_row(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
      beat_row(1'b0, 8'hFF, 8'hA5, 8'h5A, 8'h0F),
      beat_row(1'b1, 8'h00, 8'h00, 8'h00, 8'h00),
      beat_row(1'b0, 8'h11, 8'h22, 8'h33, 8'h44),
      beat_row(1'b1, 8'h00, 8'h00, 8'h00, 8'h00),
      chk_row(1'b1, 8'hFF, 8'hA5, 8'h5A, 8'h0F),
      cfg_row(REG_DIVISOR, 64'd0),
      cfg_row(REG_COEFS_MID, 64'h0000_00FF_0000_0000),
      beat_row(1'b0, 8'h80, 8'h00, 8'hFF, 8'h00),
      beat_row(1'b1, 8'h00, 8'h00, 8'h00, 8'h00),
      beat_row(1'b1, 8'h00, 8'h00, 8'h00, 8'h00),
      beat_row(1'b1, 8'h00, 8'h00, 8'h00, 8'h00),
      chk_row(1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00),
      cfg_row(REG_DIVISOR, 64'hFFFF),
      beat_row(1'b0, 8'hFF, 8'h5A, 8'hA5, 8'hF0),
      beat_row(1'b1, 8'h00, 8'h00, 8'h00, 8'h00),
      beat_row(1'b1, 8'h00, 8'h00, 8'h00, 8'h00),
      beat_row(1'b1, 8'h00, 8'h00, 8'h00, 8'h00),
      chk_row(1'b1, 8'h00, 8'h5A, 8'hA5, 8'hF0)
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].val);
      else send_beat(rows[i].flush, rows[i].luma, rows[i].c1, rows[i].c2, rows[i].a,
                     rows[i].typed, rows[i].res);
    end

    // A wide single-row frame with full coefficients, then a tall single-column frame.
    set_frame(12'd40, 12'd1, 16'd1, '1, '1, '1, 8'hFF);
    run_frame(1'b0);
    set_frame(12'd1, 12'd60, 16'hFFFF, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, 8'($urandom));
    run_frame(1'b0);

    while (n_small < 300) begin
      quiet = (n_small >= 120 && n_small < 200);
      div_pick = $urandom_range(3);
      case ($urandom_range(2))
        0: mask = '1;
        1: mask = 64'h0303_0303_0303_0303;
        default: mask = 64'h0F0F_0F0F_0F0F_0F0F;
      endcase
      set_frame(12'($urandom_range(7)), 12'($urandom_range(5)),
                (div_pick == 0) ? 16'd0 : (div_pick == 1) ? 16'd1 :
                (div_pick == 2) ? 16'($urandom_range(1, 300)) : 16'($urandom),
                {$urandom, $urandom} & mask, {$urandom, $urandom} & mask,
                {$urandom, $urandom} & mask, 8'($urandom));
      repeat ($urandom_range(1, 3)) run_frame(1'b1);
    end
    quiet = 1'b0;

    wait_idle();
    $display("Accepted %0d input beats and checked %0d output beats.", n_beats, n_results);
    $display("Frames ran from 1x1 up to 40x1 and 1x60, with zero sizes and divisor extremes.");
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
